/* sv/alarm_table_scheduler_macros.svh */
// Assertion macros for the alarm table scheduler checker.
`ifndef ALARM_TABLE_SCHEDULER_MACROS_SVH
`define ALARM_TABLE_SCHEDULER_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle.
`define ATS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define ATS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* sv/ats_pkg.sv */
// Package of shared types and constants for the alarm table scheduler.
package ats_pkg;
    localparam int MaxAlarms    = 16;
    localparam int MaxResults   = 16;
    localparam int SecsPerMin   = 60;
    localparam logic [7:0] SlackReset = 8'd5;
    localparam int TimeW = 40;
    localparam int TrigW = 41;

    localparam logic [1:0] CMD_SCHEDULE = 2'd0;
    localparam logic [1:0] CMD_CANCEL   = 2'd1;
    localparam logic [1:0] CMD_WAKEUP   = 2'd2;
    localparam logic [1:0] CMD_CLEAR    = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DISABLED  = 3'd1;
    localparam logic [2:0] ST_PAST      = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // Classified command passed from the front to the back
    typedef struct packed {
        logic [1:0]       cmd;
        logic             reject;
        logic [2:0]       status;
        logic [15:0]      alarm_id;
        logic [TrigW-1:0] trig;
        logic [TrigW:0]   lim;
    } ats_cmd_t;
endpackage

/* sv/ats_front.sv */
// Front part: accepts commands, computes trigger and limit, classifies.
module ats_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [114:0]        in_data,
    input  logic [7:0]          slack,
    output logic                q_valid,
    input  logic                q_ready,
    output ats_pkg::ats_cmd_t   q_data
);
    logic                      valid_reg;
    ats_pkg::ats_cmd_t         data_reg;
    ats_pkg::ats_cmd_t         cls;
    logic [1:0]                cmd;
    logic [15:0]               id;
    logic [39:0]               ev;
    logic [15:0]               adv;
    logic                      en;
    logic [39:0]               now;
    logic [21:0]               adv_sec;
    logic [ats_pkg::TrigW-1:0] trig;
    logic [ats_pkg::TrigW:0]   lim;

    assign cmd = in_data[1:0];
    assign id  = in_data[17:2];
    assign ev  = in_data[57:18];
    assign adv = in_data[73:58];
    assign en  = in_data[74];
    assign now = in_data[114:75];

    // Compute trigger and wakeup limit (limit can pass the top of the time range)
    assign adv_sec = 22'(adv) * 22'(ats_pkg::SecsPerMin);
    assign trig = {1'b0, ev} - {19'd0, adv_sec};
    assign lim  = {2'b0, now} + {34'd0, slack};

    // Classify the transaction
    always_comb
    begin
        cls.cmd = cmd;
        cls.alarm_id = id;
        cls.trig = trig;
        cls.lim = lim;
        cls.reject = 1'b0;
        cls.status = ats_pkg::ST_OK;
        if (cmd == ats_pkg::CMD_SCHEDULE)
        begin
            if (!en)
            begin
                cls.reject = 1'b1;
                cls.status = ats_pkg::ST_DISABLED;
            end
            else if ($signed(trig) <= $signed({1'b0, now}))
            begin
                cls.reject = 1'b1;
                cls.status = ats_pkg::ST_PAST;
            end
        end
    end

    assign in_ready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_data   = data_reg;

    // Hold the queue stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= cls;
    end
endmodule

/* sv/ats_back.sv */
// Back part: scans and updates the alarm table, emits results.
module ats_back #(
    parameter int MAX_ALARMS = ats_pkg::MaxAlarms
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  ats_pkg::ats_cmd_t q_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [71:0]       out_data,
    output logic              out_last
);
    localparam int IW = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
    localparam int CW = $clog2(MAX_ALARMS + 1);
    localparam int TW = ats_pkg::TrigW;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_EMIT  = 5'b01000,
        S_WAIT  = 5'b10000
    } state_t;

    state_t                state_reg;
    logic [MAX_ALARMS-1:0] used_reg;
    logic [15:0]           id_mem [MAX_ALARMS];
    logic [TW-1:0]         trig_mem [MAX_ALARMS];
    ats_pkg::ats_cmd_t     cmd_reg;
    logic [CW-1:0]         idx_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  found_reg;
    logic [IW-1:0]         pos_reg;
    logic                  have_reg;
    logic [TW-1:0]         min_reg;
    logic [4:0]            k_reg;
    logic                  ovalid_reg;
    logic [2:0]            st_reg;
    logic                  fv_reg;
    logic [15:0]           fid_reg;
    logic                  olast_reg;
    logic                  mode_min_reg;
    logic                  pend_fire_reg;
    logic [15:0]           pend_id_reg;
    logic [IW-1:0]         ix;
    logic [4:0]            cnt_out;

    assign ix = idx_reg[IW-1:0];
    assign q_ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign out_last = olast_reg;
    assign cnt_out = (CW > 5 && cnt_reg > CW'(31)) ? 5'd31 : 5'(cnt_reg);
    assign out_data = {5'd0, cnt_out, min_reg & {TW{have_reg}}, have_reg,
                       fid_reg, fv_reg, st_reg};

    // Run the table sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg <= '0;
            cnt_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    // Drain the last result before taking the next command
                    if (ovalid_reg)
                    begin
                        if (out_ready)
                            ovalid_reg <= 1'b0;
                    end
                    else if (q_valid)
                    begin
                        cmd_reg <= q_data;
                        idx_reg <= '0;
                        found_reg <= 1'b0;
                        pos_reg <= '0;
                        k_reg <= '0;
                        have_reg <= 1'b0;
                        state_reg <= S_SCAN;
                        if (q_data.cmd == ats_pkg::CMD_CLEAR)
                        begin
                            used_reg <= '0;
                            cnt_reg <= '0;
                            st_reg <= ats_pkg::ST_OK;
                            mode_min_reg <= 1'b1;
                        end
                        else if (q_data.reject)
                        begin
                            st_reg <= q_data.status;
                            mode_min_reg <= 1'b1;
                        end
                        else
                            mode_min_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    // Walk one entry per cycle
                    if (idx_reg == CW'(MAX_ALARMS))
                    begin
                        if (mode_min_reg)
                        begin
                            olast_reg <= 1'b1;
                            if (cmd_reg.cmd == ats_pkg::CMD_WAKEUP && k_reg != 5'd0)
                            begin
                                fv_reg <= 1'b1;
                                fid_reg <= pend_id_reg;
                            end
                            else
                            begin
                                fv_reg <= 1'b0;
                                fid_reg <= '0;
                            end
                            state_reg <= S_EMIT;
                        end
                        else if (cmd_reg.cmd == ats_pkg::CMD_WAKEUP)
                        begin
                            idx_reg <= '0;
                            state_reg <= S_WAIT;
                            pend_fire_reg <= 1'b0;
                        end
                        else if (cmd_reg.cmd == ats_pkg::CMD_CANCEL && !found_reg)
                        begin
                            st_reg <= ats_pkg::ST_NOT_FOUND;
                            idx_reg <= '0; have_reg <= 1'b0; mode_min_reg <= 1'b1;
                        end
                        else if (!found_reg && cmd_reg.cmd == ats_pkg::CMD_SCHEDULE
                                 && cnt_reg >= CW'(MAX_ALARMS))
                        begin
                            st_reg <= ats_pkg::ST_FULL;
                            idx_reg <= '0; have_reg <= 1'b0; mode_min_reg <= 1'b1;
                        end
                        else
                        begin
                            idx_reg <= CW'(pos_reg);
                            state_reg <= S_SHIFT;
                        end
                    end
                    else
                    begin
                        // Track the earliest trigger on every pass
                        if (used_reg[ix] && (!have_reg ||
                            $signed(trig_mem[ix]) < $signed(min_reg)))
                        begin
                            min_reg <= trig_mem[ix];
                            have_reg <= 1'b1;
                        end
                        if (!mode_min_reg && used_reg[ix] && !found_reg &&
                            id_mem[ix] == cmd_reg.alarm_id)
                        begin
                            found_reg <= 1'b1;
                            pos_reg <= ix;
                        end
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                S_SHIFT:
                begin
                    // Close the gap or append
                    if (!found_reg)
                    begin
                        if (cmd_reg.cmd == ats_pkg::CMD_SCHEDULE)
                        begin
                            id_mem[cnt_reg[IW-1:0]] <= cmd_reg.alarm_id;
                            trig_mem[cnt_reg[IW-1:0]] <= cmd_reg.trig;
                            used_reg[cnt_reg[IW-1:0]] <= 1'b1;
                            cnt_reg <= cnt_reg + CW'(1);
                        end
                        st_reg <= ats_pkg::ST_OK;
                        idx_reg <= '0; have_reg <= 1'b0; mode_min_reg <= 1'b1;
                        state_reg <= S_SCAN;
                    end
                    else if (idx_reg + CW'(1) < CW'(MAX_ALARMS))
                    begin
                        id_mem[ix] <= id_mem[IW'(idx_reg + CW'(1))];
                        trig_mem[ix] <= trig_mem[IW'(idx_reg + CW'(1))];
                        used_reg[ix] <= used_reg[IW'(idx_reg + CW'(1))];
                        idx_reg <= idx_reg + CW'(1);
                    end
                    else
                    begin
                        used_reg[MAX_ALARMS-1] <= 1'b0;
                        cnt_reg <= cnt_reg - CW'(1);
                        found_reg <= 1'b0;
                    end
                end
                S_WAIT:
                begin
                    // Emit due entries, holding one back to mark the last
                    if (!ovalid_reg || out_ready)
                    begin
                        if (idx_reg == CW'(MAX_ALARMS) || k_reg == 5'(ats_pkg::MaxResults))
                        begin
                            idx_reg <= '0; have_reg <= 1'b0; mode_min_reg <= 1'b1;
                            st_reg <= ats_pkg::ST_OK;
                            ovalid_reg <= 1'b0;
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            if (used_reg[ix] && $signed({trig_mem[ix][TW-1], trig_mem[ix]})
                                <= $signed(cmd_reg.lim))
                            begin
                                if (pend_fire_reg)
                                begin
                                    st_reg <= ats_pkg::ST_OK;
                                    fv_reg <= 1'b1;
                                    fid_reg <= pend_id_reg;
                                    olast_reg <= 1'b0;
                                    ovalid_reg <= 1'b1;
                                end
                                else
                                    ovalid_reg <= 1'b0;
                                pend_fire_reg <= 1'b1;
                                pend_id_reg <= id_mem[ix];
                                k_reg <= k_reg + 5'd1;
                            end
                            else
                                ovalid_reg <= 1'b0;
                            idx_reg <= idx_reg + CW'(1);
                        end
                    end
                end
                S_EMIT:
                begin
                    if (!ovalid_reg || out_ready)
                    begin
                        ovalid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

/* sv/alarm_table_scheduler.sv */
// Top level of the alarm table scheduler.
// The back part runs one command at a time against the table, one entry per
// cycle unless a due wakeup result waits on m_tready, and takes the next command
// only after its last result has been taken. A rejected schedule only scans for
// the summary; a schedule or cancel searches for the id, closes the gap (moving
// one entry per cycle) or appends as needed, then scans for the summary; a wakeup
// also walks the table for due entries. The front stage registers each command
// and holds the next command while the back is busy.
module alarm_table_scheduler #(
    parameter int MAX_ALARMS = ats_pkg::MaxAlarms
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd[1:0], alarm_id[17:2], event_time[57:18], advance_mins[73:58],
    // is_enabled[74], now_time[114:75], zero fill
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], fired_valid[3], fired_id[19:4], next_valid[20],
    // next_epoch[61:21], pending_count[66:62], zero fill
    output logic [71:0]  m_tdata,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data
);
    logic [7:0]        slack_reg;
    logic              q_valid;
    logic              q_ready;
    ats_pkg::ats_cmd_t q_data;

    assign cfg_ready = 1'b1;

    // Hold the slack register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slack_reg <= ats_pkg::SlackReset;
        else if (cfg_valid)
            slack_reg <= cfg_data;
    end

    ats_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata[114:0]),
        .slack(slack_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    ats_back #(.MAX_ALARMS(MAX_ALARMS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_data(m_tdata), .out_last(m_tlast)
    );
endmodule

/* sv/ats_checker.sv */
// Port-level checker for the alarm table scheduler, bound to the top level.
`include "alarm_table_scheduler_macros.svh"
module ats_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tlast
);
    // A stalled result holds
    `ATS_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    // A fired result is a wakeup result with status ok
    `ATS_ASSERT_IMP(a_fire_ok, clk, rst_n, m_tvalid && m_tdata[3], m_tdata[2:0] == 3'd0)
    // No fired id without fired_valid
    `ATS_ASSERT_IMP(a_fid, clk, rst_n, m_tvalid && !m_tdata[3], m_tdata[19:4] == 16'd0)
    // An empty table reports no earliest trigger
    `ATS_ASSERT_IMP(a_empty, clk, rst_n, m_tvalid && m_tdata[66:62] == 5'd0,
                    !m_tdata[20])
endmodule

bind alarm_table_scheduler ats_checker u_ats_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast)
);

/* tb/tb_alarm_table_scheduler.sv */
// Testbench for the alarm table scheduler: directed and random command streams checked against a table model.
`timescale 1ns / 1ps

module tb_alarm_table_scheduler;

    localparam int NA = 16;
    localparam int WATCH_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] alarm_id;
        logic [39:0] event_time;
        logic [15:0] advance_mins;
        logic        is_enabled;
        logic [39:0] now_time;
    } alarm_cmd_t;

    // Ordered to match {m_tdata[66:0], m_tlast}
    typedef struct packed {
        logic [4:0]  pending_count;
        logic [40:0] next_epoch;
        logic        next_valid;
        logic [15:0] fired_id;
        logic        fired_valid;
        logic [2:0]  status;
        logic        last;
    } alarm_rsp_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_data;

    alarm_table_scheduler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Model state
    logic              tbl_used [NA];
    logic [15:0]       tbl_id [NA];
    logic signed [40:0] tbl_trig [NA];
    logic [7:0]        slack;

    alarm_cmd_t cmd_queue [$];
    alarm_rsp_t expected_rsp [$];
    int         mismatches;
    int         watchdog;

    // Pool of ids so that cancels and replacements hit
    logic [15:0] id_pool [8] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h0001,
                                 16'h8000, 16'h00AA, 16'h5555, 16'hAAAA};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic queue_cmd(alarm_cmd_t c);
        cmd_queue = {cmd_queue, c};
    endtask

    task automatic queue_rsp(alarm_rsp_t r);
        expected_rsp = {expected_rsp, r};
    endtask

    function automatic alarm_rsp_t table_summary(logic [2:0] st, logic fv, logic [15:0] fid);
        alarm_rsp_t r;
        int n;
        logic have;
        logic signed [40:0] mn;
        n = 0;
        have = 1'b0;
        mn = '0;
        for (int i = 0; i < NA; i++)
        begin
            if (tbl_used[i])
            begin
                n++;
                if (!have || tbl_trig[i] < mn)
                begin
                    mn = tbl_trig[i];
                    have = 1'b1;
                end
            end
        end
        r.status = st;
        r.fired_valid = fv;
        r.fired_id = fv ? fid : 16'd0;
        r.next_valid = have;
        r.next_epoch = mn;
        r.pending_count = n[4:0];
        r.last = 1'b1;
        return r;
    endfunction

    task automatic drop_entry(int pos);
        for (int i = pos; i < NA - 1; i++)
        begin
            tbl_used[i] = tbl_used[i + 1];
            tbl_id[i] = tbl_id[i + 1];
            tbl_trig[i] = tbl_trig[i + 1];
        end
        tbl_used[NA - 1] = 1'b0;
    endtask

    function automatic int locate_id(logic [15:0] id);
        for (int i = 0; i < NA; i++)
            if (tbl_used[i] && tbl_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < NA; i++)
            if (tbl_used[i])
                n++;
        return n;
    endfunction

    // Advance the table model by one command and queue the responses it causes
    task automatic apply_alarm_cmd(alarm_cmd_t c);
        logic signed [40:0] trig;
        logic signed [41:0] lim;
        alarm_rsp_t r;
        int pos;
        int n;
        int k;
        case (c.cmd)
            ats_pkg::CMD_SCHEDULE:
            begin
                trig = $signed({1'b0, c.event_time}) - $signed({25'd0, c.advance_mins} * 41'd60);
                if (!c.is_enabled)
                    queue_rsp(table_summary(ats_pkg::ST_DISABLED, 0, 0));
                else if (trig <= $signed({1'b0, c.now_time}))
                    queue_rsp(table_summary(ats_pkg::ST_PAST, 0, 0));
                else
                begin
                    pos = locate_id(c.alarm_id);
                    if (pos < 0 && live_count() >= NA)
                        queue_rsp(table_summary(ats_pkg::ST_FULL, 0, 0));
                    else
                    begin
                        if (pos >= 0)
                            drop_entry(pos);
                        n = live_count();
                        tbl_used[n] = 1'b1;
                        tbl_id[n] = c.alarm_id;
                        tbl_trig[n] = trig;
                        queue_rsp(table_summary(ats_pkg::ST_OK, 0, 0));
                    end
                end
            end
            ats_pkg::CMD_CANCEL:
            begin
                pos = locate_id(c.alarm_id);
                if (pos < 0)
                    queue_rsp(table_summary(ats_pkg::ST_NOT_FOUND, 0, 0));
                else
                begin
                    drop_entry(pos);
                    queue_rsp(table_summary(ats_pkg::ST_OK, 0, 0));
                end
            end
            ats_pkg::CMD_WAKEUP:
            begin
                lim = $signed({2'b0, c.now_time}) + $signed({34'd0, slack});
                k = 0;
                for (int i = 0; i < NA; i++)
                begin
                    if (tbl_used[i] && k < ats_pkg::MaxResults && 42'(tbl_trig[i]) <= lim)
                    begin
                        r = table_summary(ats_pkg::ST_OK, 1, tbl_id[i]);
                        r.last = 1'b0;
                        queue_rsp(r);
                        k++;
                    end
                end
                if (k == 0)
                    queue_rsp(table_summary(ats_pkg::ST_OK, 0, 0));
                else
                    expected_rsp[$].last = 1'b1;
            end
            default:
            begin
                for (int i = 0; i < NA; i++)
                    tbl_used[i] = 1'b0;
                queue_rsp(table_summary(ats_pkg::ST_OK, 0, 0));
            end
        endcase
    endtask

    function automatic logic [39:0] rand40();
        return {8'($urandom_range(255, 0)), $urandom()};
    endfunction

    function automatic alarm_cmd_t make_cmd(logic [1:0] op, logic [15:0] id,
                                            logic [39:0] ev, logic [15:0] adv,
                                            logic en, logic [39:0] now);
        alarm_cmd_t c;
        c.cmd = op;
        c.alarm_id = id;
        c.event_time = ev;
        c.advance_mins = adv;
        c.is_enabled = en;
        c.now_time = now;
        return c;
    endfunction

    // Mostly well-formed commands near a shared clock, some noise
    function automatic alarm_cmd_t random_cmd(logic [39:0] base);
        alarm_cmd_t c;
        int sel;
        sel = $urandom_range(99, 0);
        c.alarm_id = ($urandom_range(3, 0) == 0) ? 16'($urandom()) : id_pool[$urandom_range(7, 0)];
        c.advance_mins = ($urandom_range(9, 0) == 0) ? 16'($urandom()) : 16'($urandom_range(10, 0));
        c.is_enabled = ($urandom_range(9, 0) != 0);
        c.now_time = base + 40'($urandom_range(1200, 0));
        c.event_time = base + 40'($urandom_range(2400, 0));
        if ($urandom_range(19, 0) == 0)
        begin
            c.event_time = rand40();
            c.now_time = rand40();
        end
        if (sel < 50)
            c.cmd = ats_pkg::CMD_SCHEDULE;
        else if (sel < 70)
            c.cmd = ats_pkg::CMD_CANCEL;
        else if (sel < 96)
            c.cmd = ats_pkg::CMD_WAKEUP;
        else
            c.cmd = ats_pkg::CMD_CLEAR;
        return c;
    endfunction

    // Write the slack register while the block is idle
    task automatic write_slack(logic [7:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        slack = v;
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || expected_rsp.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (2 * NA + 20) @(posedge clk);
    endtask

    task automatic fill_phase(int count, logic [39:0] base);
        for (int i = 0; i < count; i++)
            queue_cmd(random_cmd(base));
    endtask

    // Stimulus
    initial
    begin
        logic [39:0] base;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatches = 0;
        slack = ats_pkg::SlackReset;
        for (int i = 0; i < NA; i++)
            tbl_used[i] = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every command and special case
        queue_cmd(make_cmd(ats_pkg::CMD_WAKEUP, 0, 0, 0, 1, 0));
        queue_cmd(make_cmd(ats_pkg::CMD_CANCEL, 16'h1234, 0, 0, 1, 0));
        queue_cmd(make_cmd(ats_pkg::CMD_SCHEDULE, 16'hFFFF, '1, '1, 0, 0));
        queue_cmd(make_cmd(ats_pkg::CMD_SCHEDULE, 16'h0001, 100, 0, 1, 100));
        queue_cmd(make_cmd(ats_pkg::CMD_SCHEDULE, 16'h0001, 0, 16'hFFFF, 1, 0));
        queue_cmd(make_cmd(ats_pkg::CMD_SCHEDULE, 16'hFFFF, '1, 16'hFFFF, 1, 0));
        queue_cmd(make_cmd(ats_pkg::CMD_SCHEDULE, 16'h0000, '1, 0, 1, '1 - 1));
        queue_cmd(make_cmd(ats_pkg::CMD_SCHEDULE, 16'hFFFF, 1000, 1, 1, 10));
        queue_cmd(make_cmd(ats_pkg::CMD_WAKEUP, 0, 0, 0, 1, 935));
        queue_cmd(make_cmd(ats_pkg::CMD_WAKEUP, 0, 0, 0, 1, '1));
        queue_cmd(make_cmd(ats_pkg::CMD_CANCEL, 16'h0000, 0, 0, 1, 0));
        queue_cmd(make_cmd(ats_pkg::CMD_CLEAR, 0, 0, 0, 1, 0));
        queue_cmd(make_cmd(ats_pkg::CMD_CLEAR, 0, 0, 0, 1, 0));
        for (int i = 0; i < NA + 1; i++)
            queue_cmd(make_cmd(ats_pkg::CMD_SCHEDULE, 16'(i * 3), 40'(5000 - i), 0, 1, 0));
        queue_cmd(make_cmd(ats_pkg::CMD_SCHEDULE, 16'd6, 40'd7000, 0, 1, 0));
        queue_cmd(make_cmd(ats_pkg::CMD_WAKEUP, 0, 0, 0, 1, '1));
        queue_cmd(make_cmd(ats_pkg::CMD_CLEAR, 0, 0, 0, 1, 0));
        wait_drained();

        // Random phases with different slack settings
        write_slack(8'd0);
        base = rand40() >> 1;
        fill_phase(80, base);
        wait_drained();
        write_slack(8'd255);
        base = rand40() >> 1;
        fill_phase(80, base);
        wait_drained();
        write_slack(8'($urandom()));
        base = rand40() >> 1;
        fill_phase(70, base);
        wait_drained();
        write_slack(ats_pkg::SlackReset);
        fill_phase(70, 40'd0);
        wait_drained();

        if (mismatches == 0)
            $display("alarm_table_scheduler verification clean");
        else
            $display("alarm_table_scheduler verification failed");
        $finish;
    end

    // Driver: pull commands from the queue with random gaps
    int send_gap;
    initial
    begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_gap = 0;
    end

    always @(posedge clk)
    begin
        alarm_cmd_t c;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                c = cmd_queue.pop_front();
                apply_alarm_cmd(c);
                send_gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(16, 0);
            end
            if ((!s_tvalid || s_tready) && cmd_queue.size() != 0 && send_gap == 0)
            begin
                c = cmd_queue[0];
                s_tvalid <= 1'b1;
                s_tdata <= {5'd0, c.now_time, c.is_enabled, c.advance_mins,
                            c.event_time, c.alarm_id, c.cmd};
            end
            else if (!s_tvalid || s_tready)
            begin
                s_tvalid <= 1'b0;
                if (send_gap > 0)
                    send_gap--;
            end
        end
    end

    // Monitor: random backpressure and response compare
    int recv_gap;
    initial
    begin
        m_tready = 1'b0;
        recv_gap = 0;
        watchdog = 0;
    end

    always @(posedge clk)
    begin
        alarm_rsp_t got;
        alarm_rsp_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[66:0], m_tlast};
                if (expected_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: %h", got);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h actual %h", want, got);
                    end
                end
                recv_gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(16, 0);
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;

            // Watchdog on stalls
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                watchdog = 0;
            else
                watchdog++;
            if (watchdog >= WATCH_LIMIT)
            begin
                $display("alarm_table_scheduler verification failed");
                $finish;
            end
        end
    end

endmodule

/* sim.f */
+incdir+sv
sv/ats_pkg.sv
sv/ats_front.sv
sv/ats_back.sv
sv/alarm_table_scheduler.sv
sv/ats_checker.sv
tb/tb_alarm_table_scheduler.sv
